@@ hw/rtl/mep_pkg.sv @@
// Shared types and constants for the Mandelbrot escape-time pixel core.
// Field widths, register indexes, coordinate mapping constants and sequencer codes.
// No dependencies; compile first.
package mep_pkg;

    // Field widths of the request, result and configuration channels
    localparam int PIXEL_INDEX_W  = 24;
    localparam int ESCAPE_COUNT_W = 17;
    localparam int GRAY_LEVEL_W   = 8;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int IMAGE_DIM_W    = 13;
    localparam int MAX_ITER_W     = 16;

    // Register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITERATIONS = 2'd2;

    // Register reset values
    localparam logic [IMAGE_DIM_W-1:0] IMAGE_WIDTH_RST    = 13'd640;
    localparam logic [IMAGE_DIM_W-1:0] IMAGE_HEIGHT_RST   = 13'd480;
    localparam logic [MAX_ITER_W-1:0]  MAX_ITERATIONS_RST = 16'd255;

    // Coordinate mapping: c_re = (247*col - 200*w) / (100*w),
    // c_im = (1235*h - 2470*row) / (1000*h)
    localparam int RE_SCALE  = 247;
    localparam int RE_OFFSET = 200;
    localparam int RE_DEN    = 100;
    localparam int IM_SCALE  = 2470;
    localparam int IM_OFFSET = 1235;
    localparam int IM_DEN    = 1000;

    // Dividend width of the mapping numerators: 2470 * row stays below 2^36
    localparam int NUM_W = 36;

    // Bits of the second multiplier operand consumed per cycle
    localparam int MUL_CHUNK = 16;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_ROW,
        ST_PREP_RE,
        ST_DIV_RE,
        ST_FIX_RE,
        ST_DIV_IM,
        ST_FIX_IM,
        ST_CHECK,
        ST_MUL_LOAD,
        ST_MUL,
        ST_MUL_FIN,
        ST_UPDATE
    } mep_state_t;

    // Which product the shared multiplier is forming
    typedef enum logic [1:0] {
        MUL_XY,
        MUL_XX,
        MUL_YY
    } mep_mul_op_t;

endpackage

@@ hw/rtl/mep_if.sv @@
// Valid/ready channel interfaces of the Mandelbrot escape-time pixel core.
// Depends on mep_pkg for field widths.

interface mep_pixel_if;
    import mep_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [PIXEL_INDEX_W-1:0] pixel_index;

    modport source (output valid, output pixel_index, input ready);
    modport sink   (input valid, input pixel_index, output ready);
endinterface

interface mep_result_if;
    import mep_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [ESCAPE_COUNT_W-1:0] escape_count;
    logic [GRAY_LEVEL_W-1:0]   gray_level;

    modport source (output valid, output escape_count, output gray_level, input ready);
    modport sink   (input valid, input escape_count, input gray_level, output ready);
endinterface

interface mep_cfg_if;
    import mep_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/mandelbrot_escape_pixel_core.sv @@
// Mandelbrot escape-time pixel core: one request in, one escape count out.
// The core takes a new request only in its idle state, once the previous one has
// finished; the bit-serial divider and the 16-bit-chunk multiplier serialize the work.
// A finished result waits in a register until the sink takes it.
// Reset: rst_n async active low; registers return to 640, 480 and 255.
module mandelbrot_escape_pixel_core #(
    parameter int FRAC_BITS  = 28,
    parameter int COORD_BITS = 12,
    parameter int ITER_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    mep_cfg_if.sink             cfg,
    mep_pixel_if.sink           pixel,
    mep_result_if.source        result
);
    import mep_pkg::*;

    localparam int W      = 8 + FRAC_BITS;
    localparam int DIM_W  = COORD_BITS + 1;
    localparam int DEN_W  = COORD_BITS + 11;
    localparam int LIM_W  = (ITER_BITS < MAX_ITER_W) ? ITER_BITS : MAX_ITER_W;
    localparam int CNT_W  = LIM_W + 1;
    localparam int NCH    = (W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int MBW    = NCH * MUL_CHUNK;
    localparam int PW     = W + MBW;
    localparam int STEP_W = $clog2(NUM_W + FRAC_BITS + 1);
    localparam int EXT_W  = (DIM_W > IMAGE_DIM_W) ? DIM_W : IMAGE_DIM_W;

    localparam logic [W-1:0]     FX_HI   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]     FX_LO   = {1'b1, {(W-1){1'b0}}};
    localparam logic [W:0]       FOUR    = (W+1)'(4) << FRAC_BITS;
    localparam logic [EXT_W-1:0] DIM_TOP = EXT_W'(1) << COORD_BITS;

    // Saturate a magnitude with sign, rounding negative values toward minus infinity
    function automatic logic [W-1:0] sat_mag(input logic neg, input logic over,
                                             input logic [W-1:0] q, input logic remnz);
        logic [W-1:0] r;
        if (over || q[W-1])
            r = neg ? FX_LO : FX_HI;
        else if (neg)
            r = ~q + {{(W-1){1'b0}}, ~remnz};
        else
            r = q;
        return r;
    endfunction

    // Saturating signed add
    function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0]   s;
        logic [W-1:0] r;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
            r = s[W] ? FX_LO : FX_HI;
        else
            r = s[W-1:0];
        return r;
    endfunction

    function automatic logic [W-1:0] magnitude(input logic [W-1:0] v);
        return v[W-1] ? (~v + W'(1)) : v;
    endfunction

    // Zero acts as one, oversized values clamp to the coordinate range
    function automatic logic [DIM_W-1:0] eff_dim(input logic [IMAGE_DIM_W-1:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        if (e == '0)
            e = EXT_W'(1);
        else if (e > DIM_TOP)
            e = DIM_TOP;
        return e[DIM_W-1:0];
    endfunction

    // Control registers
    mep_state_t                state_reg, state_next;
    mep_mul_op_t               mul_op_reg, mul_op_next;
    logic [STEP_W-1:0]         step_cnt_reg, step_cnt_next;
    logic                      out_valid_reg, out_valid_next;
    logic [IMAGE_DIM_W-1:0]    width_cfg_reg, width_cfg_next;
    logic [IMAGE_DIM_W-1:0]    height_cfg_reg, height_cfg_next;
    logic [MAX_ITER_W-1:0]     max_iter_cfg_reg, max_iter_cfg_next;

    // Datapath registers
    logic [DIM_W-1:0]          w_reg, w_next;
    logic [DIM_W-1:0]          h_reg, h_next;
    logic [LIM_W-1:0]          lim_reg, lim_next;
    logic [PIXEL_INDEX_W-1:0]  row_reg, row_next;
    logic [NUM_W-1:0]          div_num_reg, div_num_next;
    logic [DEN_W-1:0]          div_den_reg, div_den_next;
    logic [DEN_W-1:0]          div_rem_reg, div_rem_next;
    logic [W-1:0]              div_q_reg, div_q_next;
    logic                      div_over_reg, div_over_next;
    logic                      div_neg_reg, div_neg_next;
    logic [W-1:0]              c_re_reg, c_re_next;
    logic [W-1:0]              c_im_reg, c_im_next;
    logic [W-1:0]              x_reg, x_next;
    logic [W-1:0]              y_reg, y_next;
    logic [W-1:0]              x2_reg, x2_next;
    logic [W-1:0]              y2_reg, y2_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [W-1:0]              ma_reg, ma_next;
    logic [MBW-1:0]            mb_reg, mb_next;
    logic                      mneg_reg, mneg_next;
    logic [PW-1:0]             acc_reg, acc_next;
    logic [W-1:0]              mres_reg, mres_next;
    logic [ESCAPE_COUNT_W-1:0] res_count_reg, res_count_next;
    logic [GRAY_LEVEL_W-1:0]   res_gray_reg, res_gray_next;

    // Divider step: shift one dividend bit into the remainder, subtract if it fits
    logic [DEN_W:0]   rem_sh;
    logic             div_fit;
    logic [DEN_W:0]   rem_sub;
    logic [DEN_W-1:0] div_rem_step;

    assign rem_sh       = {div_rem_reg, div_num_reg[NUM_W-1]};
    assign div_fit      = rem_sh >= {1'b0, div_den_reg};
    assign rem_sub      = rem_sh - {1'b0, div_den_reg};
    assign div_rem_step = div_fit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];

    // Mapping numerators and divisors
    logic [NUM_W-1:0] re_pos, re_off, im_pos, im_off;
    logic [DEN_W-1:0] re_den, im_den;

    assign re_pos = NUM_W'(div_rem_reg[COORD_BITS-1:0]) * NUM_W'(RE_SCALE);
    assign re_off = NUM_W'(w_reg) * NUM_W'(RE_OFFSET);
    assign im_pos = NUM_W'(row_reg) * NUM_W'(IM_SCALE);
    assign im_off = NUM_W'(h_reg) * NUM_W'(IM_OFFSET);
    assign re_den = DEN_W'(w_reg) * DEN_W'(RE_DEN);
    assign im_den = DEN_W'(h_reg) * DEN_W'(IM_DEN);

    // Multiplier step: one chunk of the second operand, high chunk first
    logic [MUL_CHUNK-1:0]   mul_chunk;
    logic [W+MUL_CHUNK-1:0] mul_pp;

    assign mul_chunk = mb_reg[MBW-1 -: MUL_CHUNK];
    assign mul_pp    = (W+MUL_CHUNK)'(ma_reg) * (W+MUL_CHUNK)'(mul_chunk);

    // Scale the finished product back to the fixed-point grid
    logic [PW-1:0] prod_sh;
    logic          prod_remnz;
    logic [W-1:0]  mul_res;

    always_comb
    begin
        if (mul_op_reg == MUL_XY)
        begin
            prod_sh    = acc_reg >> (FRAC_BITS - 1);
            prod_remnz = |acc_reg[FRAC_BITS-2:0];
        end
        else
        begin
            prod_sh    = acc_reg >> FRAC_BITS;
            prod_remnz = |acc_reg[FRAC_BITS-1:0];
        end
    end

    assign mul_res = sat_mag(mneg_reg, |prod_sh[PW-1:W], prod_sh[W-1:0], prod_remnz);

    // Multiplier operands for the current product
    logic [W-1:0] mul_a, mul_b;

    always_comb
    begin
        case (mul_op_reg)
            MUL_XY:  begin mul_a = x_reg; mul_b = y_reg; end
            MUL_XX:  begin mul_a = x_reg; mul_b = x_reg; end
            MUL_YY:  begin mul_a = y_reg; mul_b = y_reg; end
            default: begin mul_a = y_reg; mul_b = y_reg; end
        endcase
    end

    // Escape test
    logic [W:0]               sq_sum;
    logic                     keep_going;
    logic [ESCAPE_COUNT_W-1:0] count_ext;

    assign sq_sum     = {1'b0, x2_reg} + {1'b0, y2_reg};
    assign keep_going = (sq_sum <= FOUR) && (count_reg <= {1'b0, lim_reg});
    assign count_ext  = ESCAPE_COUNT_W'(count_reg);

    // Next state and outputs
    always_comb
    begin
        state_next        = state_reg;
        mul_op_next       = mul_op_reg;
        step_cnt_next     = step_cnt_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        width_cfg_next    = width_cfg_reg;
        height_cfg_next   = height_cfg_reg;
        max_iter_cfg_next = max_iter_cfg_reg;
        w_next            = w_reg;
        h_next            = h_reg;
        lim_next          = lim_reg;
        row_next          = row_reg;
        div_num_next      = div_num_reg;
        div_den_next      = div_den_reg;
        div_rem_next      = div_rem_reg;
        div_q_next        = div_q_reg;
        div_over_next     = div_over_reg;
        div_neg_next      = div_neg_reg;
        c_re_next         = c_re_reg;
        c_im_next         = c_im_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        x2_next           = x2_reg;
        y2_next           = y2_reg;
        count_next        = count_reg;
        ma_next           = ma_reg;
        mb_next           = mb_reg;
        mneg_next         = mneg_reg;
        acc_next          = acc_reg;
        mres_next         = mres_reg;
        res_count_next    = res_count_reg;
        res_gray_next     = res_gray_reg;

        // Register writes
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_IMAGE_WIDTH:    width_cfg_next    = cfg.data[IMAGE_DIM_W-1:0];
                REG_IMAGE_HEIGHT:   height_cfg_next   = cfg.data[IMAGE_DIM_W-1:0];
                REG_MAX_ITERATIONS: max_iter_cfg_next = cfg.data[MAX_ITER_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                // Take a request, latch the effective setup, split index into row and column
                if (pixel.valid)
                begin
                    w_next        = eff_dim(width_cfg_reg);
                    h_next        = eff_dim(height_cfg_reg);
                    lim_next      = max_iter_cfg_reg[LIM_W-1:0];
                    div_num_next  = NUM_W'(pixel.pixel_index);
                    div_den_next  = DEN_W'(eff_dim(width_cfg_reg));
                    div_rem_next  = '0;
                    div_q_next    = '0;
                    div_over_next = 1'b0;
                    div_neg_next  = 1'b0;
                    step_cnt_next = STEP_W'(NUM_W);
                    state_next    = ST_DIV_ROW;
                end
            end

            ST_DIV_ROW, ST_DIV_RE, ST_DIV_IM:
            begin
                // Advance the divider one quotient bit
                div_num_next  = div_num_reg << 1;
                div_rem_next  = div_rem_step;
                div_q_next    = {div_q_reg[W-2:0], div_fit};
                div_over_next = div_over_reg | div_q_reg[W-1];
                step_cnt_next = step_cnt_reg - STEP_W'(1);
                if (step_cnt_reg == STEP_W'(1))
                begin
                    case (state_reg)
                        ST_DIV_ROW: state_next = ST_PREP_RE;
                        ST_DIV_RE:  state_next = ST_FIX_RE;
                        default:    state_next = ST_FIX_IM;
                    endcase
                end
            end

            ST_PREP_RE:
            begin
                // Hold the row, start the real-axis ratio from the column
                row_next      = div_q_reg[PIXEL_INDEX_W-1:0];
                div_neg_next  = re_pos < re_off;
                div_num_next  = (re_pos < re_off) ? (re_off - re_pos) : (re_pos - re_off);
                div_den_next  = re_den;
                div_rem_next  = '0;
                div_q_next    = '0;
                div_over_next = 1'b0;
                step_cnt_next = STEP_W'(NUM_W + FRAC_BITS);
                state_next    = ST_DIV_RE;
            end

            ST_FIX_RE:
            begin
                // Store c_re, start the imaginary-axis ratio from the row
                c_re_next     = sat_mag(div_neg_reg, div_over_reg, div_q_reg, |div_rem_reg);
                div_neg_next  = im_pos > im_off;
                div_num_next  = (im_pos > im_off) ? (im_pos - im_off) : (im_off - im_pos);
                div_den_next  = im_den;
                div_rem_next  = '0;
                div_q_next    = '0;
                div_over_next = 1'b0;
                step_cnt_next = STEP_W'(NUM_W + FRAC_BITS);
                state_next    = ST_DIV_IM;
            end

            ST_FIX_IM:
            begin
                // Store c_im and clear the orbit
                c_im_next  = sat_mag(div_neg_reg, div_over_reg, div_q_reg, |div_rem_reg);
                x_next     = '0;
                y_next     = '0;
                x2_next    = '0;
                y2_next    = '0;
                count_next = '0;
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                // Iterate again, or drop the count into the output register once it is free
                if (keep_going)
                begin
                    mul_op_next = MUL_XY;
                    state_next  = ST_MUL_LOAD;
                end
                else if (!out_valid_reg || result.ready)
                begin
                    res_count_next = count_ext;
                    res_gray_next  = count_ext[GRAY_LEVEL_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_MUL_LOAD:
            begin
                // Latch operand magnitudes and the product sign
                ma_next       = magnitude(mul_a);
                mb_next       = MBW'(magnitude(mul_b));
                mneg_next     = mul_a[W-1] ^ mul_b[W-1];
                acc_next      = '0;
                step_cnt_next = STEP_W'(NCH);
                state_next    = ST_MUL;
            end

            ST_MUL:
            begin
                // Accumulate one chunk of partial products
                acc_next      = (acc_reg << MUL_CHUNK) + PW'(mul_pp);
                mb_next       = mb_reg << MUL_CHUNK;
                step_cnt_next = step_cnt_reg - STEP_W'(1);
                if (step_cnt_reg == STEP_W'(1))
                    state_next = ST_MUL_FIN;
            end

            ST_MUL_FIN:
            begin
                // Route the scaled product to its destination
                case (mul_op_reg)
                    MUL_XY:
                    begin
                        mres_next  = mul_res;
                        state_next = ST_UPDATE;
                    end
                    MUL_XX:
                    begin
                        x2_next     = mul_res;
                        mul_op_next = MUL_YY;
                        state_next  = ST_MUL_LOAD;
                    end
                    MUL_YY:
                    begin
                        y2_next    = mul_res;
                        count_next = count_reg + CNT_W'(1);
                        state_next = ST_CHECK;
                    end
                    default: state_next = ST_CHECK;
                endcase
            end

            ST_UPDATE:
            begin
                // New z from the old squares and cross product
                y_next      = sat_add(mres_reg, c_im_reg);
                x_next      = sat_add(x2_reg - y2_reg, c_re_reg);
                mul_op_next = MUL_XX;
                state_next  = ST_MUL_LOAD;
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            mul_op_reg       <= MUL_XY;
            step_cnt_reg     <= '0;
            out_valid_reg    <= 1'b0;
            width_cfg_reg    <= IMAGE_WIDTH_RST;
            height_cfg_reg   <= IMAGE_HEIGHT_RST;
            max_iter_cfg_reg <= MAX_ITERATIONS_RST;
        end
        else
        begin
            state_reg        <= state_next;
            mul_op_reg       <= mul_op_next;
            step_cnt_reg     <= step_cnt_next;
            out_valid_reg    <= out_valid_next;
            width_cfg_reg    <= width_cfg_next;
            height_cfg_reg   <= height_cfg_next;
            max_iter_cfg_reg <= max_iter_cfg_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        w_reg         <= w_next;
        h_reg         <= h_next;
        lim_reg       <= lim_next;
        row_reg       <= row_next;
        div_num_reg   <= div_num_next;
        div_den_reg   <= div_den_next;
        div_rem_reg   <= div_rem_next;
        div_q_reg     <= div_q_next;
        div_over_reg  <= div_over_next;
        div_neg_reg   <= div_neg_next;
        c_re_reg      <= c_re_next;
        c_im_reg      <= c_im_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        x2_reg        <= x2_next;
        y2_reg        <= y2_next;
        count_reg     <= count_next;
        ma_reg        <= ma_next;
        mb_reg        <= mb_next;
        mneg_reg      <= mneg_next;
        acc_reg       <= acc_next;
        mres_reg      <= mres_next;
        res_count_reg <= res_count_next;
        res_gray_reg  <= res_gray_next;
    end

    // Ports
    assign cfg.ready           = 1'b1;
    assign pixel.ready         = (state_reg == ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.escape_count = res_count_reg;
    assign result.gray_level   = res_gray_reg;

    // Iteration count never runs past the limit plus one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> (count_reg <= ({1'b0, lim_reg} + CNT_W'(1))))
        else $error("iteration count beyond limit");

    // Squares stay non-negative after saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> (!x2_reg[W-1] && !y2_reg[W-1]))
        else $error("negative square in escape test");

    // Serial units never run with an exhausted step counter
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_ROW || state_reg == ST_DIV_RE || state_reg == ST_DIV_IM ||
         state_reg == ST_MUL) |-> (step_cnt_reg != '0))
        else $error("serial step counter underflow");

endmodule

@@ tb/mandelbrot_escape_pixel_core_tb.sv @@
// Self-checking testbench for the Mandelbrot escape-time pixel core.
// Predicts each escape count in fixed point and checks every result in request order.
// Depends on mep_pkg, the channel interfaces in mep_if and the core itself.
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_core_tb;
    import mep_pkg::*;

    localparam int FRAC = 28;
    localparam int COORD = 12;
    localparam longint FX_MAX = (64'sd1 <<< (FRAC + 7)) - 1;
    localparam longint FX_MIN = -FX_MAX - 1;
    localparam longint ESCAPE_RADIUS_SQ = 64'sd4 <<< FRAC;
    localparam longint DIM_MAX = 64'sd1 <<< COORD;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int TAIL_CYCLES = 400;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [ESCAPE_COUNT_W-1:0] escape_count;
        logic [GRAY_LEVEL_W-1:0]   gray_level;
    } escape_result_t;

    logic clk;
    logic rst_n;

    mep_cfg_if    cfg_bus ();
    mep_pixel_if  pixel_bus ();
    mep_result_if result_bus ();

    mandelbrot_escape_pixel_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .pixel  (pixel_bus),
        .result (result_bus)
    );

    // Register copies as the core should hold them
    logic [IMAGE_DIM_W-1:0] width_shadow;
    logic [IMAGE_DIM_W-1:0] height_shadow;
    logic [MAX_ITER_W-1:0]  max_iter_shadow;

    escape_result_t pending_escapes[$];
    escape_result_t oldest_escape;
    int             error_count;
    int             tx_idle_pct;
    int             rx_idle_pct;
    longint         cycle_count;
    longint         cycle_limit;

    // Clock: 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Saturate to 8 integer bits plus FRAC fraction bits
    function automatic longint fx_clamp(wide_t v);
        if (v > FX_MAX)
            return FX_MAX;
        if (v < FX_MIN)
            return FX_MIN;
        return v[63:0];
    endfunction

    // floor(num * 2^FRAC / den), saturated
    function automatic longint fx_ratio_floor(longint num, longint den);
        wide_t n;
        wide_t d;
        wide_t q;
        n = num;
        n = n <<< FRAC;
        d = den;
        q = n / d;
        if (n < 0 && (n % d) != 0)
            q = q - 1;
        return fx_clamp(q);
    endfunction

    // floor(a * b / 2^shift), saturated
    function automatic longint fx_mul_floor(longint a, longint b, int shift);
        wide_t wa;
        wide_t wb;
        wide_t p;
        wa = a;
        wb = b;
        p = wa * wb;
        p = p >>> shift;
        return fx_clamp(p);
    endfunction

    // Zero acts as one, oversized values clip to the coordinate range
    function automatic longint eff_dim(logic [IMAGE_DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > DIM_MAX)
            return DIM_MAX;
        return v;
    endfunction

    // Map the pixel onto the plane and run the escape-time loop
    function automatic escape_result_t predict_escape(logic [PIXEL_INDEX_W-1:0] idx);
        longint         w;
        longint         h;
        longint         pix;
        longint         col;
        longint         row;
        longint         c_re;
        longint         c_im;
        longint         x;
        longint         y;
        longint         x2;
        longint         y2;
        longint         nx;
        longint         ny;
        wide_t          sum;
        int             count;
        escape_result_t r;
        w = eff_dim(width_shadow);
        h = eff_dim(height_shadow);
        pix = idx;
        col = pix % w;
        row = pix / w;
        c_re = fx_ratio_floor(RE_SCALE * col - RE_OFFSET * w, RE_DEN * w);
        c_im = fx_ratio_floor(IM_OFFSET * h - IM_SCALE * row, IM_DEN * h);
        x = 0;
        y = 0;
        x2 = 0;
        y2 = 0;
        count = 0;
        while (x2 + y2 <= ESCAPE_RADIUS_SQ && count <= max_iter_shadow)
        begin
            sum = fx_mul_floor(x, y, FRAC - 1);
            sum = sum + c_im;
            ny = fx_clamp(sum);
            sum = x2;
            sum = sum - y2 + c_re;
            nx = fx_clamp(sum);
            x = nx;
            y = ny;
            x2 = fx_mul_floor(x, x, FRAC);
            y2 = fx_mul_floor(y, y, FRAC);
            count++;
        end
        r.escape_count = count[ESCAPE_COUNT_W-1:0];
        r.gray_level = count[GRAY_LEVEL_W-1:0];
        return r;
    endfunction

    // Write one register and track it in the shadow copy
    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data <= data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (index)
            REG_IMAGE_WIDTH:    width_shadow = data[IMAGE_DIM_W-1:0];
            REG_IMAGE_HEIGHT:   height_shadow = data[IMAGE_DIM_W-1:0];
            REG_MAX_ITERATIONS: max_iter_shadow = data[MAX_ITER_W-1:0];
            default:            ;
        endcase
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Drop the request line and hold until every result is back
    task automatic drain_requests();
        @(negedge clk);
        pixel_bus.valid <= 1'b0;
        while (pending_escapes.size() != 0)
            @(posedge clk);
    endtask

    // Reconfigure the image once the core is idle
    task automatic set_image(logic [CFG_DATA_W-1:0] w_data, logic [CFG_DATA_W-1:0] h_data,
                             logic [CFG_DATA_W-1:0] m_data);
        drain_requests();
        write_reg(REG_IMAGE_WIDTH, w_data);
        write_reg(REG_IMAGE_HEIGHT, h_data);
        write_reg(REG_MAX_ITERATIONS, m_data);
    endtask

    // Send one pixel request, with random gaps, and queue its escape count
    task automatic send_pixel(logic [PIXEL_INDEX_W-1:0] idx);
        escape_result_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            pixel_bus.valid <= 1'b0;
            @(negedge clk);
        end
        pixel_bus.valid <= 1'b1;
        pixel_bus.pixel_index <= idx;
        do
            @(posedge clk);
        while (!pixel_bus.ready);
        predicted = predict_escape(idx);
        pending_escapes.push_back(predicted);
        // Extend the deadline by a generous multiple of this request's latency
        cycle_limit += 4 * (264 + 17 * longint'(predicted.escape_count));
    endtask

    // Image dimension data: some small, more full range, a few extremes
    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        int                     sel;
        logic [IMAGE_DIM_W-1:0] dim;
        logic [2:0]             upper;
        sel = $urandom_range(9);
        upper = 3'($urandom);
        if (sel == 0)
        begin
            sel = $urandom_range(3);
            if (sel == 0)
                dim = '0;
            else if (sel == 1)
                dim = 1;
            else if (sel == 2)
                dim = IMAGE_DIM_W'(DIM_MAX);
            else
                dim = '1;
        end
        else if (sel < 5)
            dim = IMAGE_DIM_W'($urandom_range(64, 1));
        else
            dim = IMAGE_DIM_W'($urandom_range(8191, 0));
        return {upper, dim};
    endfunction

    // Keep the iteration limit low so inside points stay cheap
    function automatic logic [CFG_DATA_W-1:0] pick_max_iter();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)
            return 255;
        if (sel < 25)
            return CFG_DATA_W'($urandom_range(80, 25));
        return CFG_DATA_W'($urandom_range(24, 0));
    endfunction

    // Pixel inside the image, any index, or rows past the bottom edge
    function automatic logic [PIXEL_INDEX_W-1:0] pick_pixel();
        longint w;
        longint h;
        longint row;
        longint col;
        longint pix;
        int     sel;
        w = eff_dim(width_shadow);
        h = eff_dim(height_shadow);
        sel = $urandom_range(99);
        col = $urandom_range(32'(w - 1), 0);
        if (sel < 80)
        begin
            row = $urandom_range(32'(h - 1), 0);
            pix = row * w + col;
        end
        else if (sel < 90)
            pix = $urandom_range(24'hFFFFFF, 0);
        else
        begin
            row = h + $urandom_range(7, 0);
            pix = row * w + col;
            if (pix > 24'hFFFFFF)
                pix = 24'hFFFFFF;
        end
        return pix[PIXEL_INDEX_W-1:0];
    endfunction

    // Reset values: corner, a point inside the set, last pixel
    task automatic test_reset_defaults();
        send_pixel(0);
        send_pixel(240 * 640 + 480);
        send_pixel(307199);
        drain_requests();
    endtask

    // Register extremes, the escape boundary, saturated rows, unknown register index
    task automatic test_register_extremes();
        set_image(1, 1, 0);
        send_pixel(0);
        send_pixel(24'hFFFFFF);
        // zero dimensions act as one
        set_image(0, 0, 1);
        send_pixel(0);
        send_pixel(1);
        // oversized dimensions clip, largest iteration limit on escaping points
        set_image(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(0);
        send_pixel(24'hFFFFFF);
        set_image(CFG_DATA_W'(DIM_MAX), CFG_DATA_W'(DIM_MAX), 16'hFFFF);
        send_pixel(4096 * 4095);
        send_pixel(4095);
        // c = -2 sits exactly on the radius; the unknown index must change nothing
        set_image(100, 2, 30);
        write_reg(REG_UNUSED, 16'd1);
        send_pixel(100);
        send_pixel(150);
        // rows past the height, the farthest of them saturating the imaginary part
        set_image(16, 4, 40);
        send_pixel(1600);
        send_pixel(16000);
        send_pixel(24'hFFFFFF);
        drain_requests();
    endtask

    // Random bursts of pixels, each burst under a fresh random image setting
    task automatic test_random_traffic(int tx_pct, int rx_pct, int n_items);
        int sent;
        int burst;
        int i;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_items)
        begin
            set_image(pick_dim(), pick_dim(), pick_max_iter());
            if ($urandom_range(3) == 0)
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
            burst = $urandom_range(80, 40);
            for (i = 0; i < burst && sent < n_items; i++)
            begin
                send_pixel(pick_pixel());
                sent++;
            end
        end
        drain_requests();
    endtask

    // Result ready with random stalls
    always @(negedge clk)
    begin
        result_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Compare each result with the oldest predicted escape
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_escapes.size() == 0)
            begin
                $error("unexpected result: escape_count %0d gray_level %0d",
                       result_bus.escape_count, result_bus.gray_level);
                error_count++;
            end
            else
            begin
                oldest_escape = pending_escapes.pop_front();
                if (result_bus.escape_count !== oldest_escape.escape_count)
                begin
                    $error("escape_count: expected %0d, actual %0d",
                           oldest_escape.escape_count, result_bus.escape_count);
                    error_count++;
                end
                if (result_bus.gray_level !== oldest_escape.gray_level)
                begin
                    $error("gray_level: expected %0d, actual %0d",
                           oldest_escape.gray_level, result_bus.gray_level);
                    error_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("[mandelbrot_escape_pixel_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        pixel_bus.valid = 1'b0;
        pixel_bus.pixel_index = '0;
        result_bus.ready = 1'b0;
        width_shadow = IMAGE_WIDTH_RST;
        height_shadow = IMAGE_HEIGHT_RST;
        max_iter_shadow = MAX_ITERATIONS_RST;
        error_count = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        cycle_count = 0;
        cycle_limit = 200000;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_random_traffic(12, 83, 630);
        test_random_traffic(83, 12, 630);
        test_random_traffic(0, 0, 630);

        // Catch any stray result after the last one
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[mandelbrot_escape_pixel_core] OK");
        else
            $display("[mandelbrot_escape_pixel_core] ERROR");
        $finish;
    end

endmodule

@@ mandelbrot_escape_pixel_core.f @@
hw/rtl/mep_pkg.sv
hw/rtl/mep_if.sv
hw/rtl/mandelbrot_escape_pixel_core.sv
tb/mandelbrot_escape_pixel_core_tb.sv
